// ----- hdl/b64u_pkg.sv -----
`timescale 1ns / 1ps

package b64u_pkg;

  typedef struct packed {
    logic [1:0] phase;
    logic [5:0] carry_bits;
    logic [2:0] carry_count;
    logic       error_seen;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_run;
    logic       error;
  } result_t;

  typedef struct packed {
    state_t     nxt;
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
  } step_t;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int QUEUE_DEPTH = 3;

  // 6-bit value to url-safe character
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v8 < 8'd26) begin
      sym_char = 8'h41 + v8;
    end else if (v8 < 8'd52) begin
      sym_char = 8'h61 + (v8 - 8'd26);
    end else if (v8 < 8'd62) begin
      sym_char = 8'h30 + (v8 - 8'd52);
    end else if (v8 == 8'd62) begin
      sym_char = 8'h2d;
    end else begin
      sym_char = 8'h5f;
    end
  endfunction

  // character to {valid, value}
  function automatic logic [6:0] sym_decode(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'h41;
      sym_decode = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      t = c - 8'h61 + 8'd26;
      sym_decode = {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      sym_decode = {1'b1, t[5:0]};
    end else if (c == 8'h2d) begin
      sym_decode = {1'b1, 6'd62};
    end else if (c == 8'h5f) begin
      sym_decode = {1'b1, 6'd63};
    end else begin
      sym_decode = {1'b0, 6'd0};
    end
  endfunction

endpackage

// ----- hdl/b64u_in_if.sv -----
`timescale 1ns / 1ps

interface b64u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink (input valid, input in_byte, input last, output ready);
endinterface

// ----- hdl/b64u_out_if.sv -----
`timescale 1ns / 1ps

interface b64u_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_run;
  logic       error;

  modport source (output valid, output out_byte, output has_byte, output end_of_run,
                  output error, input ready);
  modport sink (input valid, input out_byte, input has_byte, input end_of_run,
                input error, output ready);
endinterface

// ----- hdl/base64url_stream_codec_unit.sv -----
`timescale 1ns / 1ps

// a request's results are written into the registered result queue, which offers its head
// throughput: one request per cycle when each yields at most one result and out_s.ready
// holds; two-character requests are not taken back to back (one result per cycle out)
// a three-entry result queue sets the pace; input is taken while it holds at most one
// reset (rst_n low, synchronous): mode encode, stream state cleared, result queue emptied
module base64url_stream_codec_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_data,
  b64u_in_if.sink    in_s,
  b64u_out_if.source out_s
);

  logic                mode_r;
  b64u_pkg::state_t    st_r;
  b64u_pkg::step_t     step;
  b64u_pkg::result_t   q_r   [b64u_pkg::QUEUE_DEPTH];
  b64u_pkg::result_t   q_nxt [b64u_pkg::QUEUE_DEPTH];
  logic [1:0]          count_r;
  logic [1:0]          count_nxt;
  logic [1:0]          base;
  logic                accept;
  logic                pop;

  b64u_step u_step (
    .mode    (mode_r),
    .st      (st_r),
    .in_byte (in_s.in_byte),
    .last    (in_s.last),
    .step    (step)
  );

  assign in_s.ready       = (count_r <= 2'd1);
  assign accept           = in_s.valid && in_s.ready;
  assign out_s.valid      = (count_r != 2'd0);
  assign pop              = out_s.valid && out_s.ready;
  assign out_s.out_byte   = q_r[0].out_byte;
  assign out_s.has_byte   = q_r[0].has_byte;
  assign out_s.end_of_run = q_r[0].end_of_run;
  assign out_s.error      = q_r[0].error;

  // shift out the head, append the new results behind what remains
  always_comb begin
    for (int i = 0; i < b64u_pkg::QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < b64u_pkg::QUEUE_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    base = count_r - {1'b0, pop};
    if (accept) begin
      for (int i = 0; i < b64u_pkg::QUEUE_DEPTH; i++) begin
        if (2'(i) == base && step.n_res != 2'd0) begin
          q_nxt[i] = step.res0;
        end
        if (2'(i) == base + 2'd1 && step.n_res == 2'd2) begin
          q_nxt[i] = step.res1;
        end
      end
    end
    count_nxt = base + (accept ? step.n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < b64u_pkg::QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= b64u_pkg::MODE_ENCODE;
      st_r    <= '0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        mode_r <= cfg_data;
        st_r   <= '0;
      end else if (accept) begin
        st_r <= step.nxt;
      end
    end
  end

endmodule

// ----- hdl/b64u_step.sv -----
`timescale 1ns / 1ps

module b64u_step (
  input  logic             mode,
  input  b64u_pkg::state_t st,
  input  logic [7:0]       in_byte,
  input  logic             last,
  output b64u_pkg::step_t  step
);

  logic [2:0]  e_cnt;
  logic [13:0] e_acc;
  logic [3:0]  e_b1;
  logic [3:0]  e_b2;
  logic        e_two;
  logic        e_flush;
  logic [5:0]  e_sym0;
  logic [5:0]  e_sym1;
  logic [5:0]  e_rem;
  logic [5:0]  e_fsym;
  logic [7:0]  e_mask;

  logic [6:0]  d_dec;
  logic        d_ok;
  logic [5:0]  d_v;
  logic [1:0]  d_newphase;
  logic [2:0]  d_cnt;
  logic [11:0] d_acc;
  logic [3:0]  d_bits;
  logic        d_have;
  logic [3:0]  d_b;
  logic [7:0]  d_byte;
  logic [5:0]  d_rem;
  logic [7:0]  d_mask;

  // encode path
  always_comb begin
    e_cnt   = (st.carry_count > 3'd4) ? 3'd0 : st.carry_count;
    e_acc   = {st.carry_bits, in_byte};
    e_b1    = {1'b0, e_cnt} + 4'd2;
    e_sym0  = 6'(e_acc >> e_b1);
    e_two   = (e_b1 >= 4'd6);
    e_b2    = e_two ? (e_b1 - 4'd6) : e_b1;
    e_sym1  = 6'(e_acc >> e_b2);
    e_mask  = (8'd1 << e_b2) - 8'd1;
    e_rem   = e_acc[5:0] & e_mask[5:0];
    e_fsym  = 6'(e_rem << (4'd6 - e_b2));
    e_flush = last && (e_b2 != 4'd0) && !e_two;
  end

  // decode path
  always_comb begin
    d_dec      = b64u_pkg::sym_decode(in_byte);
    d_ok       = d_dec[6];
    d_v        = d_dec[5:0];
    d_newphase = st.phase + 2'd1;
    d_cnt      = (st.carry_count > 3'd6) ? 3'd0 : st.carry_count;
    d_acc      = {st.carry_bits, d_v};
    d_bits     = {1'b0, d_cnt} + 4'd6;
    d_have     = (d_bits >= 4'd8);
    d_b        = d_have ? (d_bits - 4'd8) : d_bits;
    d_byte     = 8'(d_acc >> d_b);
    d_mask     = (8'd1 << d_b) - 8'd1;
    d_rem      = d_acc[5:0] & d_mask[5:0];
  end

  always_comb begin
    step = '0;
    if (mode == b64u_pkg::MODE_ENCODE) begin
      step.res0.out_byte = b64u_pkg::sym_char(e_sym0);
      step.res0.has_byte = 1'b1;
      step.res1.out_byte = b64u_pkg::sym_char(e_two ? e_sym1 : e_fsym);
      step.res1.has_byte = 1'b1;
      step.res1.end_of_run = last;
      if (e_two || e_flush) begin
        step.n_res = 2'd2;
      end else begin
        step.n_res = 2'd1;
        step.res0.end_of_run = last;
      end
      if (!last) begin
        step.nxt.carry_bits  = e_rem;
        step.nxt.carry_count = e_b2[2:0];
      end
    end else begin
      if (!d_ok || st.error_seen) begin
        if (last) begin
          step.n_res = 2'd1;
          step.res0.end_of_run = 1'b1;
          step.res0.error = 1'b1;
        end else begin
          step.nxt = st;
          step.nxt.phase = d_newphase;
          step.nxt.error_seen = 1'b1;
        end
      end else if (last && d_newphase == 2'd1) begin
        step.n_res = 2'd1;
        step.res0.end_of_run = 1'b1;
        step.res0.error = 1'b1;
      end else if (last) begin
        step.n_res = 2'd1;
        step.res0.out_byte = d_have ? d_byte : 8'd0;
        step.res0.has_byte = d_have;
        step.res0.end_of_run = 1'b1;
      end else begin
        step.nxt.carry_bits  = d_rem;
        step.nxt.carry_count = d_b[2:0];
        step.nxt.phase       = d_newphase;
        step.res0.out_byte   = d_byte;
        step.res0.has_byte   = 1'b1;
        step.n_res           = d_have ? 2'd1 : 2'd0;
      end
    end
  end

endmodule
